[design/bale_pkg.sv]
// Shared types and codes for the bounded array list engine.
// No dependencies; used by every file of the block.
`default_nettype none

package bale_pkg;

  // Fixed field widths of the request and result words
  localparam int FUNC_W   = 4;
  localparam int POS_W    = 6;
  localparam int ITEM_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Request function codes
  localparam logic [FUNC_W-1:0] FN_APPEND = 4'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 4'd2;
  localparam logic [FUNC_W-1:0] FN_ERASE  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 4'd4;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_FIRST  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_LAST   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd8;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         pos;
    logic signed [ITEM_W-1:0] item;
  } in_word_t;

  typedef struct packed {
    logic signed [ITEM_W-1:0] value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } out_word_t;

  // Broadcast command to the cell row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

endpackage

`default_nettype wire

[design/bale_cell.sv]
// One storage cell of the list row: holds one element.
// Depends on bale_pkg (cell_op_t).
`default_nettype none

module bale_cell #(
  parameter int DATA_WIDTH = bale_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire bale_pkg::cell_op_t    op,
  input  wire logic [IDX_W-1:0]      at,
  input  wire logic [DATA_WIDTH-1:0] item,
  input  wire logic [DATA_WIDTH-1:0] left_d,
  input  wire logic [DATA_WIDTH-1:0] right_d,
  output logic      [DATA_WIDTH-1:0] data_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    unique case (op)
      bale_pkg::CELL_HOLD: begin
      end
      bale_pkg::CELL_WRITE: begin
        if (at == MY_IDX) data_r <= item;
      end
      // cells above the slot take their lower neighbor
      bale_pkg::CELL_INSERT: begin
        if (MY_IDX > at) data_r <= left_d;
        else if (MY_IDX == at) data_r <= item;
      end
      // cells at or above the slot take their upper neighbor
      bale_pkg::CELL_ERASE: begin
        if (MY_IDX >= at) data_r <= right_d;
      end
      default: begin
      end
    endcase
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

[design/bounded_array_list_engine.sv]
// Bounded array list engine: a dense list of up to CAPACITY elements.
// The result word is registered; while the output is stalled it waits in the skid slot first.
// Throughput: one request per cycle while in_stall is low; insert/erase shift the whole cell row at once.
// A two-slot output buffer lets a request in while one result waits (in_stall = slot 2 busy).
// Reset (rst_n low, sync) clears the count and output valids; cells are not cleared.
// Depends on bale_pkg and bale_cell.
`default_nettype none

module bounded_array_list_engine #(
  parameter int CAPACITY   = bale_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bale_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bale_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bale_pkg::out_word_t      out_word
);

  localparam int IW   = $clog2(CAPACITY);        // element index width
  localparam int CW   = $clog2(CAPACITY + 1);    // element count width
  localparam int CMPW = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // ---------------- list state ----------------
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  // cell row
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  bale_pkg::cell_op_t    cell_op;
  logic [IW-1:0]         cell_at;
  logic [DATA_WIDTH-1:0] cell_item;

  // ---------------- output buffer ----------------
  logic                  out_valid_r;
  bale_pkg::out_word_t   out_word_r;
  logic                  skid_valid_r;
  bale_pkg::out_word_t   skid_word_r;

  logic                  acc;
  logic                  out_free;

  // request decode
  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       pos_ext;
  logic [IW-1:0]         pos_idx;
  logic [IW-1:0]         last_idx;
  logic [IW-1:0]         rd_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  is_full;
  logic                  is_empty;
  logic                  pos_lt;   // pos addresses a stored element
  logic                  pos_le;   // pos is a legal insert slot
  bale_pkg::out_word_t   res;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assign cnt_ext   = CMPW'(count_r);
  assign pos_ext   = CMPW'(in_word.pos);
  assign pos_idx   = IW'(in_word.pos);
  assign last_idx  = IW'(count_r - CW'(1));
  assign is_full   = (count_r == CAP_CNT);
  assign is_empty  = (count_r == '0);
  assign pos_lt    = (pos_ext < cnt_ext);
  assign pos_le    = (pos_ext <= cnt_ext);
  assign cell_item = DATA_WIDTH'($unsigned(in_word.item));

  // read index: first, last or the requested position
  always_comb begin
    if (in_word.func == bale_pkg::FN_FIRST) rd_idx = '0;
    else if (in_word.func == bale_pkg::FN_LAST) rd_idx = last_idx;
    else rd_idx = pos_idx;
  end

  // read select across the cell row
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_idx == IW'(i)) rd_data = cell_q[i];
    end
  end

  // Decode: status, new count and the command for the cell row.
  // A failing request leaves everything as it was.
  always_comb begin
    res.value  = '0;
    res.status = bale_pkg::ST_OK;
    count_nxt  = count_r;
    cell_op    = bale_pkg::CELL_HOLD;
    cell_at    = pos_idx;
    unique case (in_word.func)
      bale_pkg::FN_APPEND: begin
        if (is_full) begin
          res.status = bale_pkg::ST_FULL;
        end else begin
          cell_op   = bale_pkg::CELL_WRITE;
          cell_at   = IW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end
      bale_pkg::FN_POP: begin
        if (is_empty) res.status = bale_pkg::ST_EMPTY;
        else count_nxt = count_r - CW'(1);
      end
      // full wins over a bad position
      bale_pkg::FN_INSERT: begin
        if (is_full) begin
          res.status = bale_pkg::ST_FULL;
        end else if (!pos_le) begin
          res.status = bale_pkg::ST_RANGE;
        end else begin
          cell_op   = bale_pkg::CELL_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      bale_pkg::FN_ERASE: begin
        if (!pos_lt) begin
          res.status = bale_pkg::ST_RANGE;
        end else begin
          cell_op   = bale_pkg::CELL_ERASE;
          count_nxt = count_r - CW'(1);
        end
      end
      bale_pkg::FN_READ: begin
        if (!pos_lt) res.status = bale_pkg::ST_RANGE;
        else res.value = bale_pkg::ITEM_W'(rd_data);
      end
      bale_pkg::FN_WRITE: begin
        if (!pos_lt) res.status = bale_pkg::ST_RANGE;
        else cell_op = bale_pkg::CELL_WRITE;
      end
      bale_pkg::FN_FIRST, bale_pkg::FN_LAST: begin
        if (is_empty) res.status = bale_pkg::ST_EMPTY;
        else res.value = bale_pkg::ITEM_W'(rd_data);
      end
      bale_pkg::FN_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // unused function codes
        res.status = bale_pkg::ST_RANGE;
      end
    endcase
    res.count = bale_pkg::COUNT_W'(count_nxt);
    if (!acc) cell_op = bale_pkg::CELL_HOLD;
  end

  // ---------------- cell row ----------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    // end cells feed back their own word; only the top cell loads it, on an erase, past the new count
    if (g == 0) begin : g_lo
      assign left_d = cell_q[g];
    end else begin : g_lo_n
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right_d = cell_q[g];
    end else begin : g_hi_n
      assign right_d = cell_q[g+1];
    end

    bale_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IW),
      .IDX        (g)
    ) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .at      (cell_at),
      .item    (cell_item),
      .left_d  (left_d),
      .right_d (right_d),
      .data_q  (cell_q[g])
    );
  end

  // ---------------- count and output buffer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (acc) count_r <= count_nxt;
      if (out_free) begin
        // skid word goes first to keep order; no accept while it is held
        if (skid_valid_r) begin
          out_word_r   <= skid_word_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (acc) begin
          out_word_r  <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (acc) begin
        skid_word_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[design/bale_chk.sv]
// Port-level checker for the bounded array list engine, bound to the top level.
// Depends on bale_pkg.
`default_nettype none

module bale_chk #(
  parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire bale_pkg::in_word_t  in_word,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bale_pkg::out_word_t out_word
);

  localparam logic [bale_pkg::COUNT_W-1:0] CAP_CNT = bale_pkg::COUNT_W'(CAPACITY);

  // held result word must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a full rejection reports a full list
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == bale_pkg::ST_FULL) |-> out_word.count == CAP_CNT)
    else $error("full status with list not full");

  // an empty report means an empty list
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == bale_pkg::ST_EMPTY) |-> out_word.count == '0)
    else $error("empty status with nonzero count");

  // failed requests read nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != bale_pkg::ST_OK) |-> out_word.value == '0)
    else $error("nonzero value on failed request");

endmodule

bind bounded_array_list_engine bale_chk #(.CAPACITY(CAPACITY)) u_bale_chk (.*);

`default_nettype wire
